/* design/assert_macros.svh */
// assertion helpers for the sorted id table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SIT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sit_pkg.sv */
`default_nettype none

package sit_pkg;

    localparam int ID_W   = 32;
    localparam int HND_W  = 16;
    localparam int POS_W  = 7;

    localparam logic [ID_W-1:0] ID_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] REQ_REGISTER   = 2'd0;
    localparam logic [1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [1:0] REQ_FIND       = 2'd2;
    localparam logic [1:0] REQ_ALLOCATE   = 2'd3;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_ZERO    = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ID_W-1:0]  network_id;
        logic [HND_W-1:0] object_handle;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [HND_W-1:0] found_handle;
        logic [POS_W-1:0] entry_position;
        logic [ID_W-1:0]  new_id;
        logic [POS_W-1:0] entry_total;
    } t_out;

endpackage

`default_nettype wire

/* design/sit_mem.sv */
`default_nettype none

module sit_mem #(
    parameter int DEPTH = 64,
    parameter int HW    = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [sit_pkg::ID_W-1:0] i_wid,
    input  wire logic [HW-1:0]            i_whnd,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [sit_pkg::ID_W-1:0] o_rid,
    output logic      [HW-1:0]            o_rhnd
);

    logic [sit_pkg::ID_W-1:0] r_id_mem  [DEPTH];
    logic [HW-1:0]            r_hnd_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_id_mem[i_waddr]  <= i_wid;
            r_hnd_mem[i_waddr] <= i_whnd;
        end
        o_rid  <= r_id_mem[i_raddr];
        o_rhnd <= r_hnd_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/sorted_id_table_core.sv */
// a zero id skips the scan for find, register and unregister; allocate always scans
// find, register and unregister compare up to count + 1 entries, allocate up to 2 * count + 1
// register shifts entries pos to count - 1 up, unregister shifts pos + 1 to count - 1 down
// one transaction at a time; no new request is taken until the result enters the output
// scan and shift share one read port and one write port of the entry memory
// reset: synchronous active low; count 0, dynamic counter 1, memory contents left undefined
`default_nettype none

`include "assert_macros.svh"

module sorted_id_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire sit_pkg::t_in              i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output sit_pkg::t_out                  o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [sit_pkg::ID_W-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = AW + 1;
    localparam int HW = (HANDLE_BITS < sit_pkg::HND_W) ? HANDLE_BITS : sit_pkg::HND_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHUP = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [IW-1:0]            r_idx, n_idx;
    logic [IW-1:0]            r_pos, n_pos;
    logic [IW-1:0]            r_count, n_count;
    logic [sit_pkg::ID_W-1:0] r_dyn, n_dyn;
    logic [sit_pkg::ID_W-1:0] r_cand, n_cand;
    logic [1:0]               r_req, n_req;
    logic [sit_pkg::ID_W-1:0] r_key, n_key;
    logic [HW-1:0]            r_hnd, n_hnd;
    sit_pkg::t_out            r_res, n_res;
    sit_pkg::t_out            r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [sit_pkg::ID_W-1:0] mem_wid;
    logic [HW-1:0]            mem_whnd;
    logic [AW-1:0]            mem_raddr;
    logic [sit_pkg::ID_W-1:0] rd_id;
    logic [HW-1:0]            rd_hnd;

    logic                     in_fire;
    logic                     scan_end;
    logic                     scan_ge;
    logic                     scan_hit;

    sit_mem #(
        .DEPTH (TABLE_DEPTH),
        .HW    (HW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wid   (mem_wid),
        .i_whnd  (mem_whnd),
        .i_raddr (mem_raddr),
        .o_rid   (rd_id),
        .o_rhnd  (rd_hnd)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_fire     = i_in_valid && o_in_ready;

    // shared compare unit
    assign scan_end = (r_idx == r_count);
    assign scan_ge  = (rd_id >= r_cand);
    assign scan_hit = !scan_end && (rd_id == r_cand);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_count     = r_count;
        n_dyn       = r_dyn;
        n_cand      = r_cand;
        n_req       = r_req;
        n_key       = r_key;
        n_hnd       = r_hnd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wid     = rd_id;
        mem_whnd    = rd_hnd;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_req       = i_in.req_type;
                    n_key       = i_in.network_id;
                    n_hnd       = i_in.object_handle[HW-1:0];
                    n_idx       = '0;
                    n_res       = '0;
                    n_res.entry_total = sit_pkg::POS_W'(r_count);
                    if (i_in.req_type == sit_pkg::REQ_ALLOCATE) begin
                        n_cand  = (r_dyn == '0) ? sit_pkg::ID_W'(1) : r_dyn;
                        n_state = S_SCAN;
                    end else if (i_in.network_id == '0) begin
                        n_res.status = sit_pkg::STATUS_ZERO;
                        n_state      = S_DONE;
                    end else begin
                        n_cand  = i_in.network_id;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!scan_end && !scan_ge) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_pos                = r_idx;
                    n_res.entry_position = sit_pkg::POS_W'(r_idx);
                    case (r_req)
                        sit_pkg::REQ_ALLOCATE: begin
                            if (scan_hit) begin
                                if (r_cand == sit_pkg::ID_MAX) begin
                                    n_cand = sit_pkg::ID_W'(1);
                                    n_idx  = '0;
                                end else begin
                                    n_cand = r_cand + 1'b1;
                                    n_idx  = r_idx + 1'b1;
                                end
                            end else begin
                                n_res.new_id = r_cand;
                                n_dyn        = r_cand + 1'b1;
                                n_state      = S_DONE;
                            end
                        end
                        sit_pkg::REQ_FIND: begin
                            n_res.found        = scan_hit;
                            n_res.found_handle = scan_hit ? sit_pkg::HND_W'(rd_hnd) : '0;
                            n_res.status       = scan_hit ? sit_pkg::STATUS_DONE
                                                          : sit_pkg::STATUS_IGNORED;
                            n_state            = S_DONE;
                        end
                        sit_pkg::REQ_REGISTER: begin
                            if (scan_hit) begin
                                n_res.found        = 1'b1;
                                n_res.found_handle = sit_pkg::HND_W'(rd_hnd);
                                n_res.status       = sit_pkg::STATUS_IGNORED;
                                n_state            = S_DONE;
                            end else if (r_count == IW'(TABLE_DEPTH)) begin
                                n_res.status = sit_pkg::STATUS_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_SHUP;
                            end
                        end
                        default: begin
                            if (scan_hit) begin
                                n_res.found        = 1'b1;
                                n_res.found_handle = sit_pkg::HND_W'(rd_hnd);
                                n_idx              = r_idx + 1'b1;
                                n_state            = S_SHDN;
                            end else begin
                                n_res.status = sit_pkg::STATUS_IGNORED;
                                n_state      = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_SHUP: begin
                mem_we = 1'b1;
                if (r_idx == r_pos) begin
                    mem_waddr         = r_pos[AW-1:0];
                    mem_wid           = r_key;
                    mem_whnd          = r_hnd;
                    n_count           = r_count + 1'b1;
                    n_res.entry_total = sit_pkg::POS_W'(r_count + 1'b1);
                    n_state           = S_DONE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_SHDN: begin
                if (r_idx >= r_count) begin
                    n_count           = r_count - 1'b1;
                    n_res.entry_total = sit_pkg::POS_W'(r_count - 1'b1);
                    n_state           = S_DONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_idx - 1'b1);
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_dyn = i_cfg_wdata;
        end
    end

    // read address runs one step ahead of the sequencer index
    assign mem_raddr = (n_state == S_SHUP) ? AW'(n_idx - 1'b1) : n_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_dyn       <= sit_pkg::ID_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_dyn       <= n_dyn;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_cand <= n_cand;
        r_req  <= n_req;
        r_key  <= n_key;
        r_hnd  <= n_hnd;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    `SIT_ASSERT_SAME(a_count_bound, 1'b1, r_count <= IW'(TABLE_DEPTH), "entry count over depth")
    `SIT_ASSERT_SAME(a_scan_bound, r_state == S_SCAN, r_idx <= r_count, "scan past entry count")
    `SIT_ASSERT_SAME(a_shup_bound, r_state == S_SHUP, (r_idx >= r_pos) && (r_idx < IW'(TABLE_DEPTH)), "shift up index out of range")
    `SIT_ASSERT_SAME(a_full_flag, (r_state == S_DONE) && (r_res.status == sit_pkg::STATUS_FULL) && (r_req == sit_pkg::REQ_REGISTER), r_count == IW'(TABLE_DEPTH), "full status with free entries")
    `SIT_ASSERT_NEXT(a_out_load, (r_state == S_DONE) && (!r_out_valid || i_out_ready), r_out_valid && (r_state == S_IDLE), "result not loaded")

endmodule

`default_nettype wire
